@@ rtl/fat_tree_next_hop_macros.svh @@
// Assertion macros for the fat tree next-hop block.
`ifndef FAT_TREE_NEXT_HOP_MACROS_SVH
`define FAT_TREE_NEXT_HOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FTNH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fat_tree_next_hop check failed");
// next-cycle implication
`define FTNH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fat_tree_next_hop check failed");
`else
`define FTNH_ASSERT_IMP(lbl, ante, cons)
`define FTNH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/ftnh_pkg.sv @@
// Shared types, constants and helpers of the fat tree next-hop block.
package ftnh_pkg;

  localparam int unsigned ARITY_DEF   = 8;
  localparam int unsigned RECIP_SHIFT = 24;

  typedef enum logic [2:0] {
    LYR_HOST = 3'd1,
    LYR_EDGE = 3'd2,
    LYR_AGG  = 3'd3,
    LYR_CORE = 3'd4
  } layer_t;

  // per-node decode: validity, (index - 1) divided by h and by h*h, which half the node sits in, and the middle flag
  typedef struct packed {
    logic       valid;
    logic [7:0] div_h;
    logic [7:0] div_hh;
    logic       low_half;
    logic       mid;
  } node_info_t;

  typedef struct packed {
    logic [2:0] layer;
    logic [7:0] index;
    logic       arrived;
  } hop_t;

  // floor(a / d) for a < 256, with m = ceil(2^RECIP_SHIFT / d)
  function automatic logic [7:0] ftnh_div(input logic [7:0] a, input logic [23:0] m);
    logic [31:0] p;
    p = 32'(a) * 32'(m);
    return 8'(p >> RECIP_SHIFT);
  endfunction

endpackage

@@ rtl/fat_tree_next_hop.sv @@
// Top level of the fat tree next-hop block: input stage, routing, output stage.
//
//   channel | dir | ports                       | beat
//   in      | in  | in_tvalid/tready/tdata[23:0] | current node and destination
//   out     | out | out_tvalid/tready/tdata[15:0]/tuser | next hop, arrived flag
//
// One beat per cycle sustained while out_tready does not stall the output.
// The routing path is one pass from the input register to the output register:
// reciprocal multiplies per node decode, then the pod base multiply and compares.
// rst_n (synchronous, active low) empties both stages; there is no startup sweep.
// A stalled output holds its beat; an empty input stage still takes one more beat.
`include "fat_tree_next_hop_macros.svh"

module fat_tree_next_hop #(
  parameter int unsigned FAT_TREE_ARITY = ftnh_pkg::ARITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] cur_layer, [10:3] cur_index, [13:11] dest_layer, [21:14] dest_index
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] next_layer, [10:3] next_index
  output logic [15:0] out_tdata,
  // [0] arrived
  output logic        out_tuser
);
  import ftnh_pkg::*;

  logic        s1_v_r, s1_v_nxt;
  logic [21:0] s1_data_r;
  logic        out_v_r, out_v_nxt;
  hop_t        out_hop_r;
  logic        s1_adv;
  node_info_t  cur_info, dest_info;
  hop_t        hop;

  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;

  always_comb begin
    s1_v_nxt  = s1_v_r;
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = s1_v_r;
    end
    if (in_tready) begin
      s1_v_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata[21:0];
    end
    if (s1_adv && s1_v_r) begin
      out_hop_r <= hop;
    end
  end

  ftnh_decode #(.ARITY(FAT_TREE_ARITY)) u_cur_dec (
    .layer (s1_data_r[2:0]),
    .index (s1_data_r[10:3]),
    .info  (cur_info)
  );

  ftnh_decode #(.ARITY(FAT_TREE_ARITY)) u_dest_dec (
    .layer (s1_data_r[13:11]),
    .index (s1_data_r[21:14]),
    .info  (dest_info)
  );

  ftnh_route #(.ARITY(FAT_TREE_ARITY)) u_route (
    .cur_layer  (s1_data_r[2:0]),
    .cur_index  (s1_data_r[10:3]),
    .dest_layer (s1_data_r[13:11]),
    .dest_index (s1_data_r[21:14]),
    .cur_info   (cur_info),
    .dest_info  (dest_info),
    .hop        (hop)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_hop_r.index, out_hop_r.layer};
  assign out_tuser  = out_hop_r.arrived;

  `FTNH_ASSERT_NXT(a_in_to_s1, in_tvalid && in_tready, s1_v_r)
  `FTNH_ASSERT_NXT(a_s1_to_out, s1_v_r && s1_adv, out_tvalid)
  `FTNH_ASSERT_IMP(a_take_while_stalled, out_tvalid && !out_tready && !s1_v_r, in_tready)

endmodule

@@ rtl/ftnh_decode.sv @@
// Node decoder: validity, quotients by h and h*h, half and middle flag of one fat tree node.
module ftnh_decode #(
  parameter int unsigned ARITY = ftnh_pkg::ARITY_DEF
) (
  input  logic [2:0]           layer,
  input  logic [7:0]           index,
  output ftnh_pkg::node_info_t info
);
  import ftnh_pkg::*;

  localparam int unsigned H     = ARITY / 2;
  localparam int unsigned HH    = H * H;
  localparam int unsigned HOSTS = ARITY * ARITY * ARITY / 4;
  localparam int unsigned NSW   = ARITY * H;
  localparam int unsigned NCORE = ARITY * ARITY / 4;

  localparam logic [23:0] RECIP_H  = 24'(((1 << RECIP_SHIFT) + H - 1) / H);
  localparam logic [23:0] RECIP_HH = 24'(((1 << RECIP_SHIFT) + HH - 1) / HH);

  localparam logic [8:0] LIM_HOST = 9'((HOSTS > 256) ? 256 : HOSTS);
  localparam logic [8:0] LIM_SW   = 9'((NSW > 256) ? 256 : NSW);
  localparam logic [8:0] LIM_CORE = 9'((NCORE > 256) ? 256 : NCORE);

  logic [7:0] idx_m1;
  logic [7:0] q_h;
  logic [7:0] rem;
  logic [8:0] rem2p1;
  logic [8:0] idx_ext;

  assign idx_m1  = index - 8'd1;
  assign q_h     = ftnh_div(idx_m1, RECIP_H);
  assign rem     = idx_m1 - 8'(16'(q_h) * 16'(H));
  assign rem2p1  = {rem, 1'b1};
  assign idx_ext = {1'b0, index};

  always_comb begin
    info.div_h    = q_h;
    info.div_hh   = ftnh_div(idx_m1, RECIP_HH);
    info.valid    = 1'b0;
    info.low_half = 1'b1;
    info.mid      = 1'b0;
    case (layer)
      LYR_HOST: info.valid = (index != 8'd0) && (idx_ext <= LIM_HOST);
      LYR_EDGE: info.valid = (index != 8'd0) && (idx_ext <= LIM_SW);
      LYR_AGG: begin
        info.valid    = (index != 8'd0) && (idx_ext <= LIM_SW);
        info.low_half = rem2p1 < 9'(H);
        info.mid      = rem2p1 == 9'(H);
      end
      LYR_CORE: begin
        info.valid    = (index != 8'd0) && (idx_ext <= LIM_CORE);
        info.low_half = 10'({index, 1'b0}) < 10'(NCORE + 1);
      end
      default: info.valid = 1'b0;
    endcase
  end

endmodule

@@ rtl/ftnh_route.sv @@
// Up/down routing decision from the decoded current and destination nodes.
module ftnh_route #(
  parameter int unsigned ARITY = ftnh_pkg::ARITY_DEF
) (
  input  logic [2:0]           cur_layer,
  input  logic [7:0]           cur_index,
  input  logic [2:0]           dest_layer,
  input  logic [7:0]           dest_index,
  input  ftnh_pkg::node_info_t cur_info,
  input  ftnh_pkg::node_info_t dest_info,
  output ftnh_pkg::hop_t       hop
);
  import ftnh_pkg::*;

  localparam int unsigned H     = ARITY / 2;
  localparam int unsigned NSW   = ARITY * H;
  localparam int unsigned NCORE = ARITY * ARITY / 4;
  localparam logic [7:0] NSW_LO   = 8'(NSW);
  localparam logic [7:0] NCORE_LO = 8'(NCORE);

  logic [9:0] cur_base, cur_pmin, cur_pmax;
  logic [7:0] dpod_q;
  logic [9:0] dest_base, dest_pmin, dest_pmax;
  logic       dagg, dcore, first, own, same_pod;

  assign cur_base  = 10'(10'(cur_info.div_h) * 10'(H));
  assign cur_pmin  = cur_base + 10'd1;
  assign cur_pmax  = cur_base + 10'(H);
  assign dpod_q    = (dest_layer == LYR_HOST) ? dest_info.div_hh : dest_info.div_h;
  assign dest_base = 10'(10'(dpod_q) * 10'(H));
  assign dest_pmin = dest_base + 10'd1;
  assign dest_pmax = dest_base + 10'(H);
  assign dagg      = dest_layer == LYR_AGG;
  assign dcore     = dest_layer == LYR_CORE;
  assign first     = dest_info.low_half;
  assign own       = cur_info.low_half;
  assign same_pod  = dest_info.div_h == cur_info.div_h;

  always_comb begin
    hop.layer   = cur_layer;
    hop.index   = cur_index;
    hop.arrived = 1'b0;
    if (!cur_info.valid || !dest_info.valid) begin
      hop.arrived = 1'b0;
    end else if (cur_layer == dest_layer && cur_index == dest_index) begin
      hop.arrived = 1'b1;
    end else begin
      case (cur_layer)
        LYR_HOST: begin
          hop.layer = LYR_EDGE;
          hop.index = cur_info.div_h + 8'd1;
        end
        LYR_EDGE: begin
          hop.layer = LYR_AGG;
          if (dest_layer == LYR_HOST &&
              ({1'b0, dest_info.div_h} + 9'd1) == {1'b0, cur_index}) begin
            hop.layer = LYR_HOST;
            hop.index = dest_index;
          end else if (dagg && same_pod) begin
            hop.index = dest_index;
          end else begin
            hop.index = first ? cur_pmin[7:0] : cur_pmax[7:0];
          end
        end
        LYR_AGG: begin
          if (dagg) begin
            hop.layer = (own == first) ? LYR_CORE : LYR_EDGE;
            hop.index = (own == first) ? (first ? 8'd1 : NCORE_LO) : cur_index;
          end else if (dcore) begin
            hop.layer = (own == first) ? LYR_CORE : LYR_EDGE;
            hop.index = (own == first) ? dest_index : cur_index;
          end else if (dest_layer == LYR_EDGE && same_pod) begin
            hop.layer = LYR_EDGE;
            hop.index = dest_index;
          end else if (dest_layer == LYR_HOST && dest_info.div_hh == cur_info.div_h) begin
            hop.layer = LYR_EDGE;
            hop.index = dest_info.div_h + 8'd1;
          end else begin
            hop.layer = LYR_CORE;
            hop.index = own ? 8'd1 : NCORE_LO;
          end
        end
        LYR_CORE: begin
          hop.layer = LYR_AGG;
          if (dcore) begin
            hop.index = own ? 8'd1 : NSW_LO;
          end else if (dagg && own == first) begin
            // second-half middle switch drops to the pod's last switch
            hop.index = (first || !dest_info.mid) ? dest_index : dest_pmax[7:0];
          end else begin
            hop.index = own ? dest_pmin[7:0] : dest_pmax[7:0];
          end
        end
        default: hop.arrived = 1'b0;
      endcase
    end
  end

endmodule
